>>> sv/btm_pkg.sv
// ----------------------------------------------------------------------------
// Battery trend monitor package
// Shared widths, register indexes and reset values for the trend monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package btm_pkg;

   // Window geometry
   localparam int WINDOW = 16;
   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);

   // Field widths
   localparam int VOLT_W     = 13;
   localparam int EMA_W      = 21;
   localparam int ALPHA_W    = 17;
   localparam int SLOPE_W    = 24;
   localparam int CAP_W      = 10;
   localparam int FRAC_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Window sums and products
   localparam int SY_W   = VOLT_W + CNT_W;
   localparam int SX_W   = 2 * CNT_W;
   localparam int SXX_W  = 3 * CNT_W;
   localparam int SXY_W  = VOLT_W + 2 * CNT_W;
   localparam int PROD_W = 3 * CNT_W + VOLT_W;
   localparam int DEN_W  = 4 * CNT_W;

   // Shared divider
   localparam int SLOPE_SHIFT = 10;
   localparam int SNUM_W      = PROD_W + SLOPE_SHIFT;
   localparam int CNUM_W      = 31;
   localparam int CSPAN_W     = VOLT_W + FRAC_W;
   localparam int DIVN_W      = (SNUM_W > CNUM_W) ? SNUM_W : CNUM_W;
   localparam int DIVD_W      = (DEN_W > CSPAN_W) ? DEN_W : CSPAN_W;
   localparam int DCNT_W      = $clog2(DIVN_W + 1);

   // EMA arithmetic
   localparam int EMA_PROD_W = ALPHA_W + EMA_W;
   localparam int EMA_SHIFT  = 16;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
   localparam int EMA_ROUND  = 32768;

   // Capacity scale
   localparam int CAP_SCALE = 1000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EMA_ALPHA    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_VOLTAGE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_VOLTAGE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LEVEL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_LIMIT   = 3'd4;

   // Register reset values
   localparam logic [ALPHA_W-1:0]        ALPHA_RST = 17'd6554;
   localparam logic [VOLT_W-1:0]         FULL_RST  = 13'd4200;
   localparam logic [VOLT_W-1:0]         EMPTY_RST = 13'd3300;
   localparam logic [VOLT_W-1:0]         LOW_RST   = 13'd3400;
   localparam logic signed [SLOPE_W-1:0] DROP_RST  = -24'sd51200;

endpackage

`default_nettype wire

>>> sv/btm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module btm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                                     clock,
   input  wire                                     wr_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                        wr_data,
   input  wire                                     rd_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/battery_trend_monitor_unit.sv
// ----------------------------------------------------------------------------
// Battery trend monitor
// A request runs the EMA update, window write, window walk, regression products
// and both divisions before its result loads the response register; the next
// request is taken only after that, so requests are handled one at a time.
// The window walk reads one RAM entry per cycle and one shared restoring
// divider runs the slope and then the capacity division, one bit per cycle.
// Synchronous reset clears the EMA, window fill and registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_trend_monitor_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [btm_pkg::VOLT_W-1:0]            req_voltage_mv,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [btm_pkg::EMA_W-1:0]             rsp_ema_q8_mv,
   output logic [btm_pkg::CAP_W-1:0]             rsp_capacity_tenths,
   output logic signed [btm_pkg::SLOPE_W-1:0]    rsp_trend_slope,
   output logic                                  rsp_drop_flag,
   output logic                                  rsp_low_flag,
   input  wire                                   csr_wr_en,
   input  wire  [btm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [btm_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_EMA,
      ST_WALK,
      ST_PROD,
      ST_DIFF,
      ST_SDIV,
      ST_CDIV,
      ST_DONE
   } state_type;

   state_type state_ff;

   // Configuration registers
   logic [btm_pkg::ALPHA_W-1:0]        alpha_ff;
   logic [btm_pkg::VOLT_W-1:0]         full_ff;
   logic [btm_pkg::VOLT_W-1:0]         empty_ff;
   logic [btm_pkg::VOLT_W-1:0]         low_ff;
   logic signed [btm_pkg::SLOPE_W-1:0] drop_ff;

   // Block state
   logic [btm_pkg::EMA_W-1:0]  ema_ff;
   logic [btm_pkg::CNT_W-1:0]  fill_ff;
   logic [btm_pkg::IDX_W-1:0]  head_ff;
   logic [btm_pkg::VOLT_W-1:0] volt_ff;

   // EMA products
   logic [btm_pkg::EMA_PROD_W-1:0] p1_ff;
   logic [btm_pkg::EMA_PROD_W-1:0] p2_ff;

   // Window walk
   logic [btm_pkg::CNT_W-1:0] iss_ff;
   logic                      pend_ff;
   logic [btm_pkg::IDX_W-1:0] x_ff;
   logic [btm_pkg::SY_W-1:0]  sy_ff;
   logic [btm_pkg::SX_W-1:0]  sx_ff;
   logic [btm_pkg::SXX_W-1:0] sxx_ff;
   logic [btm_pkg::SXY_W-1:0] sxy_ff;

   // Regression products and capacity operands
   logic [btm_pkg::PROD_W-1:0] nsxy_ff;
   logic [btm_pkg::PROD_W-1:0] sxsy_ff;
   logic [btm_pkg::DEN_W-1:0]  nsxx_ff;
   logic [btm_pkg::DEN_W-1:0]  sx2_ff;
   logic [btm_pkg::CNUM_W-1:0] capnum_ff;
   logic [btm_pkg::VOLT_W-1:0] span_mag_ff;
   logic                       cap_skip_ff;
   logic                       slope_neg_ff;
   logic                       slope_skip_ff;

   // Shared divider
   logic [btm_pkg::DIVN_W-1:0] dq_ff;
   logic [btm_pkg::DIVD_W-1:0] dr_ff;
   logic [btm_pkg::DIVD_W-1:0] dd_ff;
   logic [btm_pkg::DCNT_W-1:0] dcnt_ff;

   // Results
   logic signed [btm_pkg::SLOPE_W-1:0] slope_ff;
   logic [btm_pkg::CAP_W-1:0]          cap_ff;
   logic                               rsp_valid_ff;
   logic [btm_pkg::EMA_W-1:0]          rsp_ema_ff;
   logic [btm_pkg::CAP_W-1:0]          rsp_cap_ff;
   logic signed [btm_pkg::SLOPE_W-1:0] rsp_slope_ff;
   logic                               rsp_drop_ff;
   logic                               rsp_low_ff;

   // RAM port signals
   logic                        ram_we;
   logic [btm_pkg::IDX_W-1:0]   ram_waddr;
   logic                        ram_re;
   logic [btm_pkg::IDX_W-1:0]   ram_raddr;
   logic [btm_pkg::VOLT_W-1:0]  ram_rdata;

   // Combinational helpers
   logic                           win_full_in;
   logic [btm_pkg::IDX_W-1:0]      head_in;
   logic [btm_pkg::IDX_W:0]        phys_in;
   logic [btm_pkg::ALPHA_W-1:0]    alpha_eff_in;
   logic [btm_pkg::EMA_PROD_W:0]   ema_sum_in;
   logic [btm_pkg::EMA_W-1:0]      ema_in;
   logic [btm_pkg::EMA_W-1:0]      e256_in;
   logic                           cap_num_neg_in;
   logic [btm_pkg::EMA_W-1:0]      cap_mag_in;
   logic                           span_neg_in;
   logic [btm_pkg::VOLT_W-1:0]     span_mag_in;
   logic                           slope_neg_in;
   logic [btm_pkg::PROD_W-1:0]     slope_mag_in;
   logic [btm_pkg::DEN_W-1:0]      den_in;
   logic [btm_pkg::DIVD_W:0]       div_sh_in;
   logic                           div_ge_in;
   logic [btm_pkg::DIVD_W:0]       div_rem_in;
   logic                           div_done_in;
   logic [btm_pkg::SLOPE_W-1:0]    slope_negq_in;
   logic signed [btm_pkg::SLOPE_W-1:0] slope_sat_in;
   logic [btm_pkg::CAP_W-1:0]      cap_in;

   // Window sample memory
   btm_ram #(
      .WIDTH (btm_pkg::VOLT_W),
      .DEPTH (btm_pkg::WINDOW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (volt_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= btm_pkg::ALPHA_RST;
         full_ff  <= btm_pkg::FULL_RST;
         empty_ff <= btm_pkg::EMPTY_RST;
         low_ff   <= btm_pkg::LOW_RST;
         drop_ff  <= btm_pkg::DROP_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            btm_pkg::CSR_EMA_ALPHA:     alpha_ff <= csr_wdata[btm_pkg::ALPHA_W-1:0];
            btm_pkg::CSR_FULL_VOLTAGE:  full_ff  <= csr_wdata[btm_pkg::VOLT_W-1:0];
            btm_pkg::CSR_EMPTY_VOLTAGE: empty_ff <= csr_wdata[btm_pkg::VOLT_W-1:0];
            btm_pkg::CSR_LOW_LEVEL:     low_ff   <= csr_wdata[btm_pkg::VOLT_W-1:0];
            btm_pkg::CSR_DROP_LIMIT:    drop_ff  <= $signed(csr_wdata[btm_pkg::SLOPE_W-1:0]);
            default: ;
         endcase
      end
   end

   // Window addressing: a circular buffer whose oldest entry sits at the head.
   always_comb begin
      win_full_in = (fill_ff == btm_pkg::CNT_W'(btm_pkg::WINDOW));
      head_in = (head_ff == btm_pkg::IDX_W'(btm_pkg::WINDOW - 1)) ? '0 : head_ff + 1'b1;
      phys_in = {1'b0, head_ff} + {1'b0, iss_ff[btm_pkg::IDX_W-1:0]};
      ram_we = (state_ff == ST_MUL);
      ram_waddr = win_full_in ? head_ff : fill_ff[btm_pkg::IDX_W-1:0];
      ram_re = (state_ff == ST_WALK) && (iss_ff < fill_ff);
      if (phys_in >= (btm_pkg::IDX_W + 1)'(btm_pkg::WINDOW)) begin
         ram_raddr = btm_pkg::IDX_W'(phys_in - (btm_pkg::IDX_W + 1)'(btm_pkg::WINDOW));
      end else begin
         ram_raddr = phys_in[btm_pkg::IDX_W-1:0];
      end
   end

   // EMA rounding and the capacity and slope operand preparation.
   always_comb begin
      alpha_eff_in = (alpha_ff > btm_pkg::ALPHA_ONE) ? btm_pkg::ALPHA_ONE : alpha_ff;
      ema_sum_in = (btm_pkg::EMA_PROD_W + 1)'(p1_ff) + (btm_pkg::EMA_PROD_W + 1)'(p2_ff)
                 + (btm_pkg::EMA_PROD_W + 1)'(btm_pkg::EMA_ROUND);
      if (ema_ff == '0) begin
         ema_in = {volt_ff, {btm_pkg::FRAC_W{1'b0}}};
      end else begin
         ema_in = ema_sum_in[btm_pkg::EMA_SHIFT +: btm_pkg::EMA_W];
      end
      e256_in = {empty_ff, {btm_pkg::FRAC_W{1'b0}}};
      cap_num_neg_in = (ema_ff < e256_in);
      cap_mag_in = cap_num_neg_in ? (e256_in - ema_ff) : (ema_ff - e256_in);
      span_neg_in = (full_ff < empty_ff);
      span_mag_in = span_neg_in ? (empty_ff - full_ff) : (full_ff - empty_ff);
      slope_neg_in = (sxsy_ff > nsxy_ff);
      slope_mag_in = slope_neg_in ? (sxsy_ff - nsxy_ff) : (nsxy_ff - sxsy_ff);
      den_in = nsxx_ff - sx2_ff;
   end

   // One restoring divider step per cycle, plus result saturation.
   always_comb begin
      div_sh_in = {dr_ff, dq_ff[btm_pkg::DIVN_W-1]};
      div_ge_in = (div_sh_in >= {1'b0, dd_ff});
      div_rem_in = div_ge_in ? (div_sh_in - {1'b0, dd_ff}) : div_sh_in;
      div_done_in = (dcnt_ff == btm_pkg::DCNT_W'(btm_pkg::DIVN_W));
      slope_negq_in = -dq_ff[btm_pkg::SLOPE_W-1:0];
      priority if (slope_skip_ff) begin
         slope_sat_in = '0;
      end else if (slope_neg_ff) begin
         if (dq_ff > btm_pkg::DIVN_W'(1 << (btm_pkg::SLOPE_W - 1))) begin
            slope_sat_in = {1'b1, {(btm_pkg::SLOPE_W - 1){1'b0}}};
         end else begin
            slope_sat_in = $signed(slope_negq_in);
         end
      end else begin
         if (dq_ff > btm_pkg::DIVN_W'((1 << (btm_pkg::SLOPE_W - 1)) - 1)) begin
            slope_sat_in = {1'b0, {(btm_pkg::SLOPE_W - 1){1'b1}}};
         end else begin
            slope_sat_in = $signed(dq_ff[btm_pkg::SLOPE_W-1:0]);
         end
      end
      priority if (cap_skip_ff) begin
         cap_in = '0;
      end else if (dq_ff > btm_pkg::DIVN_W'(btm_pkg::CAP_SCALE)) begin
         cap_in = btm_pkg::CAP_W'(btm_pkg::CAP_SCALE);
      end else begin
         cap_in = dq_ff[btm_pkg::CAP_W-1:0];
      end
   end

   // Sequencer: EMA update, window write, window walk, two divisions, result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ema_ff       <= '0;
         fill_ff      <= '0;
         head_ff      <= '0;
         pend_ff      <= 1'b0;
      end else begin
         // A taken response clears valid unless a new one is loaded this cycle.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  volt_ff  <= req_voltage_mv;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               p1_ff <= btm_pkg::EMA_PROD_W'(alpha_eff_in)
                      * btm_pkg::EMA_PROD_W'({volt_ff, {btm_pkg::FRAC_W{1'b0}}});
               p2_ff <= btm_pkg::EMA_PROD_W'(btm_pkg::ALPHA_ONE - alpha_eff_in)
                      * btm_pkg::EMA_PROD_W'(ema_ff);
               if (win_full_in) begin
                  head_ff <= head_in;
               end else begin
                  fill_ff <= fill_ff + 1'b1;
               end
               state_ff <= ST_EMA;
            end
            ST_EMA: begin
               ema_ff   <= ema_in;
               iss_ff   <= '0;
               pend_ff  <= 1'b0;
               sy_ff    <= '0;
               sx_ff    <= '0;
               sxx_ff   <= '0;
               sxy_ff   <= '0;
               state_ff <= ST_WALK;
            end
            ST_WALK: begin
               if (pend_ff) begin
                  sy_ff  <= sy_ff + btm_pkg::SY_W'(ram_rdata);
                  sx_ff  <= sx_ff + btm_pkg::SX_W'(x_ff);
                  sxx_ff <= sxx_ff + btm_pkg::SXX_W'(x_ff) * btm_pkg::SXX_W'(x_ff);
                  sxy_ff <= sxy_ff + btm_pkg::SXY_W'(x_ff) * btm_pkg::SXY_W'(ram_rdata);
               end
               if (iss_ff < fill_ff) begin
                  pend_ff <= 1'b1;
                  x_ff    <= iss_ff[btm_pkg::IDX_W-1:0];
                  iss_ff  <= iss_ff + 1'b1;
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     state_ff <= ST_PROD;
                  end
               end
            end
            ST_PROD: begin
               nsxy_ff <= btm_pkg::PROD_W'(fill_ff) * btm_pkg::PROD_W'(sxy_ff);
               sxsy_ff <= btm_pkg::PROD_W'(sx_ff) * btm_pkg::PROD_W'(sy_ff);
               nsxx_ff <= btm_pkg::DEN_W'(fill_ff) * btm_pkg::DEN_W'(sxx_ff);
               sx2_ff  <= btm_pkg::DEN_W'(sx_ff) * btm_pkg::DEN_W'(sx_ff);
               capnum_ff <= btm_pkg::CNUM_W'(cap_mag_in)
                          * btm_pkg::CNUM_W'(btm_pkg::CAP_SCALE);
               span_mag_ff <= span_mag_in;
               cap_skip_ff <= (span_mag_in == '0) || (cap_num_neg_in != span_neg_in);
               state_ff <= ST_DIFF;
            end
            ST_DIFF: begin
               slope_neg_ff  <= slope_neg_in;
               slope_skip_ff <= (fill_ff < btm_pkg::CNT_W'(2)) || (den_in == '0);
               dq_ff   <= btm_pkg::DIVN_W'({slope_mag_in, {btm_pkg::SLOPE_SHIFT{1'b0}}});
               dd_ff   <= btm_pkg::DIVD_W'(den_in);
               dr_ff   <= '0;
               dcnt_ff <= '0;
               state_ff <= ST_SDIV;
            end
            ST_SDIV: begin
               if (!div_done_in) begin
                  dr_ff   <= div_rem_in[btm_pkg::DIVD_W-1:0];
                  dq_ff   <= {dq_ff[btm_pkg::DIVN_W-2:0], div_ge_in};
                  dcnt_ff <= dcnt_ff + 1'b1;
               end else begin
                  slope_ff <= slope_sat_in;
                  dq_ff    <= btm_pkg::DIVN_W'(capnum_ff);
                  dd_ff    <= btm_pkg::DIVD_W'({span_mag_ff, {btm_pkg::FRAC_W{1'b0}}});
                  dr_ff    <= '0;
                  dcnt_ff  <= '0;
                  state_ff <= ST_CDIV;
               end
            end
            ST_CDIV: begin
               if (!div_done_in) begin
                  dr_ff   <= div_rem_in[btm_pkg::DIVD_W-1:0];
                  dq_ff   <= {dq_ff[btm_pkg::DIVN_W-2:0], div_ge_in};
                  dcnt_ff <= dcnt_ff + 1'b1;
               end else begin
                  cap_ff   <= cap_in;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ema_ff   <= ema_ff;
                  rsp_cap_ff   <= cap_ff;
                  rsp_slope_ff <= slope_ff;
                  rsp_drop_ff  <= (slope_ff < drop_ff);
                  rsp_low_ff   <= (volt_ff < low_ff);
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Ports
   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ema_q8_mv       = rsp_ema_ff;
   assign rsp_capacity_tenths = rsp_cap_ff;
   assign rsp_trend_slope     = rsp_slope_ff;
   assign rsp_drop_flag       = rsp_drop_ff;
   assign rsp_low_flag        = rsp_low_ff;

   // The fill count never runs past the window depth.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= btm_pkg::CNT_W'(btm_pkg::WINDOW))
      else $error("window fill count exceeds depth");

   // The head only moves once the window is full.
   assert property (@(posedge clock) disable iff (reset)
      (head_ff != '0) |-> (fill_ff == btm_pkg::CNT_W'(btm_pkg::WINDOW)))
      else $error("window head moved before the window filled");

   // A nonzero slope needs at least two samples in the window.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_slope_ff != '0)) |-> (fill_ff >= btm_pkg::CNT_W'(2)))
      else $error("slope reported with fewer than two samples");

   // Capacity stays inside its clamp.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_cap_ff <= btm_pkg::CAP_W'(btm_pkg::CAP_SCALE)))
      else $error("capacity above full scale");

   // A finished result always reaches the output register.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("finished request not presented");

endmodule

`default_nettype wire
